>>> rtl/wsfp_pkg.sv
package wsfp_pkg;

    // Defaults for the top-level parameters
    localparam int LENGTH_BITS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Width of the payload_length result field
    localparam int PAYLOAD_LEN_W = 64;

    // Seven-bit length codes that select an extended length field
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Byte counts of the variable header fields
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Result kinds, carried on m_tuser
    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_PAY  = 2'd1,
        KIND_STAT = 2'd2
    } kind_t;

    // End-of-frame status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_MISMATCH = 2'd2
    } status_t;

    // Decoded header fields
    typedef struct packed {
        logic                     fin;
        logic [2:0]               reserved_bits;
        logic [3:0]               opcode;
        logic                     masked;
        logic [6:0]               length_code;
        logic [PAYLOAD_LEN_W-1:0] payload_length;
        logic [31:0]              mask_key;
    } hdr_t;

    // One queued request: the results caused by one input byte
    typedef struct packed {
        logic       has_main;   // header or payload result present
        logic       main_pay;   // main result is a payload byte
        logic       has_stat;   // end status follows
        status_t    status;
        logic [7:0] data_byte;
        hdr_t       hdr;
    } cmd_t;

    // One result as driven on the master side
    typedef struct packed {
        kind_t      kind;
        hdr_t       hdr;
        logic [7:0] data_byte;
        status_t    status;
        logic       last;
    } res_t;

endpackage

>>> rtl/wsfp_front.sv
module wsfp_front import wsfp_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    typedef enum logic [5:0] {
        PH_FIRST  = 6'b000001,
        PH_SECOND = 6'b000010,
        PH_EXT    = 6'b000100,
        PH_KEY    = 6'b001000,
        PH_PAY    = 6'b010000,
        PH_OVER   = 6'b100000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic                   demask_reg;
    logic [7:0]             hdr1_reg, hdr1_next;
    logic [7:0]             hdr2_reg, hdr2_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic [3:0]             left_reg, left_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             seen_reg, seen_next;

    logic       accept;
    logic       hdr_emit;
    logic       pay_emit;
    logic       stat_emit;
    status_t    status;
    logic [7:0] data;
    logic [7:0] key_byte;
    logic [6:0] code;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign code     = in_byte[6:0];
    // Key byte for this payload index: index 0 takes the most significant byte
    assign key_byte = key_reg[{~seen_reg, 3'b000} +: 8];

    // Decode one frame byte
    always_comb begin
        phase_next = phase_reg;
        hdr1_next  = hdr1_reg;
        hdr2_next  = hdr2_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        key_next   = key_reg;
        seen_next  = seen_reg;
        hdr_emit   = 1'b0;
        pay_emit   = 1'b0;
        stat_emit  = 1'b0;
        status     = ST_OK;
        data       = in_byte;
        if (accept) begin
            unique case (phase_reg)
                PH_SECOND: begin
                    hdr2_next = in_byte;
                    if (code == LEN_CODE_EXT16) begin
                        left_next  = EXT16_BYTES;
                        phase_next = PH_EXT;
                    end else if (code == LEN_CODE_EXT64) begin
                        left_next  = EXT64_BYTES;
                        phase_next = PH_EXT;
                    end else begin
                        len_next = LENGTH_BITS'(code);
                        if (in_byte[7]) begin
                            left_next  = KEY_BYTES;
                            phase_next = PH_KEY;
                        end else begin
                            hdr_emit   = 1'b1;
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_EXT: begin
                    // Shift in big-endian; high bits fall off a narrow accumulator
                    len_next  = {len_reg[LENGTH_BITS-9:0], in_byte};
                    left_next = left_reg - 4'd1;
                    if (left_next == 4'd0) begin
                        if (hdr2_reg[7]) begin
                            left_next  = KEY_BYTES;
                            phase_next = PH_KEY;
                        end else begin
                            hdr_emit   = 1'b1;
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_KEY: begin
                    key_next  = {key_reg[23:0], in_byte};
                    left_next = left_reg - 4'd1;
                    if (left_next == 4'd0) begin
                        hdr_emit   = 1'b1;
                        phase_next = PH_PAY;
                    end
                end
                PH_PAY: begin
                    if (cnt_reg < len_reg) begin
                        pay_emit = 1'b1;
                        if (demask_reg && hdr2_reg[7]) begin
                            data = in_byte ^ key_byte;
                        end
                        cnt_next  = cnt_reg + LENGTH_BITS'(1);
                        seen_next = seen_reg + 2'd1;
                    end else begin
                        phase_next = PH_OVER;
                    end
                end
                PH_OVER: begin
                    // Drop excess bytes until the frame ends
                end
                default: begin
                    hdr1_next  = in_byte;
                    hdr2_next  = '0;
                    len_next   = '0;
                    cnt_next   = '0;
                    left_next  = '0;
                    key_next   = '0;
                    seen_next  = '0;
                    phase_next = PH_SECOND;
                end
            endcase

            // Close the frame on its last byte
            if (in_last) begin
                stat_emit = 1'b1;
                if (phase_next == PH_SECOND) begin
                    status = ST_SHORT;
                end else if (phase_next == PH_PAY) begin
                    status = (cnt_next == len_next) ? ST_OK : ST_MISMATCH;
                end else begin
                    status = ST_MISMATCH;
                end
                phase_next = PH_FIRST;
            end
        end
    end

    // Build the request for the back end
    always_comb begin
        q_cmd                    = '0;
        q_cmd.has_main           = hdr_emit || pay_emit;
        q_cmd.main_pay           = pay_emit;
        q_cmd.has_stat           = stat_emit;
        q_cmd.status             = status;
        q_cmd.data_byte          = data;
        q_cmd.hdr.fin            = hdr1_reg[7];
        q_cmd.hdr.reserved_bits  = hdr1_reg[6:4];
        q_cmd.hdr.opcode         = hdr1_reg[3:0];
        q_cmd.hdr.masked         = hdr2_next[7];
        q_cmd.hdr.length_code    = hdr2_next[6:0];
        q_cmd.hdr.payload_length = PAYLOAD_LEN_W'(len_next);
        q_cmd.hdr.mask_key       = key_next;
    end

    assign q_push = accept && (hdr_emit || pay_emit || stat_emit);

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FIRST;
            demask_reg <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            if (cfg_we) begin
                demask_reg <= cfg_wdata;
            end
        end
    end

    // Frame fields, all set or cleared on the first header byte
    always_ff @(posedge aclk) begin
        hdr1_reg <= hdr1_next;
        hdr2_reg <= hdr2_next;
        len_reg  <= len_next;
        cnt_reg  <= cnt_next;
        left_reg <= left_next;
        key_reg  <= key_next;
        seen_reg <= seen_next;
    end

endmodule

>>> rtl/wsfp_fifo.sv
module wsfp_fifo import wsfp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store requests
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("request popped from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/wsfp_back.sv
module wsfp_back import wsfp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_empty,
    input  cmd_t q_head,
    output logic q_pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic valid_reg, valid_next;
    logic sel_reg, sel_next;   // main result of the head already sent
    res_t res_reg, res_next;
    logic load;

    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Expand the head request into one or two results
    always_comb begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = !q_empty;
            if (!q_empty) begin
                res_next = '0;
                if (!sel_reg && q_head.has_main) begin
                    if (q_head.main_pay) begin
                        res_next.kind      = KIND_PAY;
                        res_next.data_byte = q_head.data_byte;
                    end else begin
                        res_next.kind = KIND_HDR;
                        res_next.hdr  = q_head.hdr;
                    end
                    res_next.last = !q_head.has_stat;
                    if (q_head.has_stat) begin
                        sel_next = 1'b1;
                    end else begin
                        q_pop = 1'b1;
                    end
                end else begin
                    res_next.kind   = KIND_STAT;
                    res_next.status = q_head.status;
                    res_next.last   = 1'b1;
                    q_pop           = 1'b1;
                    sel_next        = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    // Hold result payload
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    a_sel_on_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> (!q_empty && q_head.has_main && q_head.has_stat))
        else $error("split request without a pending status");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.kind == KIND_STAT) |-> res_reg.last)
        else $error("status result not marked last");

endmodule

>>> rtl/websocket_frame_parser.sv
// A result passes through the request queue and then the output register to the master side.
// Throughput: one frame byte per cycle unless the queue is full; the last byte of a frame
// that also carries a header or payload result yields two results, one after the other.
// A request queue between decoder and output stage absorbs such bursts and downstream stalls.
// Reset: aresetn is synchronous, active low; it empties the queue, expects a new frame
// header and turns payload unmasking on.
module websocket_frame_parser import wsfp_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_wdata,    // unmask enable
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,      // frame_byte
    input  logic         s_tlast,      // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // fin, reserved_bits, opcode, masked, length_code, payload_length, mask_key,
    // data_byte, status, zero fill
    output logic [127:0] m_tdata,
    output logic [1:0]   m_tuser,      // kind
    output logic         m_tlast       // last
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_in;
    cmd_t q_head;
    res_t res;

    wsfp_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    wsfp_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    wsfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (res)
    );

    // Pack the result fields, first field in the lowest bits
    assign m_tdata = {6'b000000,
                      res.status,
                      res.data_byte,
                      res.hdr.mask_key,
                      res.hdr.payload_length,
                      res.hdr.length_code,
                      res.hdr.masked,
                      res.hdr.opcode,
                      res.hdr.reserved_bits,
                      res.hdr.fin};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

>>> dv/websocket_frame_parser_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the config port, predicts the parser's results
// for every accepted frame byte and compares each result field by field.
module websocket_frame_parser_checker import wsfp_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    output int           mismatches,
    output int           pending,
    output int           results_seen
);

    typedef enum logic [2:0] {
        P_HDR0,
        P_HDR1,
        P_EXTLEN,
        P_KEY,
        P_DATA,
        P_DROP
    } parse_phase_t;

    localparam logic [63:0] LEN_KEEP = 64'((65'd1 << LENGTH_BITS) - 65'd1);

    // Shadow copy of the parser state
    parse_phase_t phase;
    logic [7:0]   hdr0;
    logic [7:0]   hdr1;
    logic [63:0]  frame_len;
    logic [3:0]   field_left;
    logic [31:0]  key;
    logic [63:0]  data_count;
    logic [1:0]   key_idx;
    logic         demask;

    res_t step_results[$];
    res_t due_results[$];

    function automatic res_t header_result();
        res_t r;
        r = '0;
        r.kind = KIND_HDR;
        r.hdr.fin = hdr0[7];
        r.hdr.reserved_bits = hdr0[6:4];
        r.hdr.opcode = hdr0[3:0];
        r.hdr.masked = hdr1[7];
        r.hdr.length_code = hdr1[6:0];
        r.hdr.payload_length = frame_len;
        r.hdr.mask_key = key;
        return r;
    endfunction

    // Length known: collect the key next, or the header is complete
    task automatic finish_length();
        if (hdr1[7]) begin
            field_left = KEY_BYTES;
            phase = P_KEY;
        end else begin
            step_results.push_back(header_result());
            phase = P_DATA;
        end
    endtask

    task automatic reset_model();
        phase = P_HDR0;
        hdr0 = '0;
        hdr1 = '0;
        frame_len = '0;
        field_left = '0;
        key = '0;
        data_count = '0;
        key_idx = '0;
        demask = 1'b1;
    endtask

    // Advance the shadow parser by one frame byte and queue its results
    task automatic take_byte(input logic [7:0] b, input logic lastb);
        res_t    r;
        status_t st;
        step_results.delete();
        case (phase)
            P_HDR1: begin
                hdr1 = b;
                if (b[6:0] == LEN_CODE_EXT16) begin
                    field_left = EXT16_BYTES;
                    phase = P_EXTLEN;
                end else if (b[6:0] == LEN_CODE_EXT64) begin
                    field_left = EXT64_BYTES;
                    phase = P_EXTLEN;
                end else begin
                    frame_len = {57'd0, b[6:0]} & LEN_KEEP;
                    finish_length();
                end
            end
            P_EXTLEN: begin
                frame_len = {frame_len[55:0], b} & LEN_KEEP;
                field_left = field_left - 4'd1;
                if (field_left == 4'd0) finish_length();
            end
            P_KEY: begin
                key = {key[23:0], b};
                field_left = field_left - 4'd1;
                if (field_left == 4'd0) begin
                    step_results.push_back(header_result());
                    phase = P_DATA;
                end
            end
            P_DATA: begin
                if (data_count < frame_len) begin
                    r = '0;
                    r.kind = KIND_PAY;
                    r.data_byte = (demask && hdr1[7]) ? (b ^ key[8 * (3 - key_idx) +: 8]) : b;
                    step_results.push_back(r);
                    data_count = data_count + 64'd1;
                    key_idx = key_idx + 2'd1;
                end else begin
                    phase = P_DROP;
                end
            end
            P_DROP: begin
            end
            default: begin
                hdr0 = b;
                hdr1 = '0;
                frame_len = '0;
                field_left = '0;
                key = '0;
                data_count = '0;
                key_idx = '0;
                phase = P_HDR1;
            end
        endcase

        // End of frame: report status and expect a new header
        if (lastb) begin
            if (phase == P_HDR1)
                st = ST_SHORT;
            else if (phase == P_DATA)
                st = (data_count == frame_len) ? ST_OK : ST_MISMATCH;
            else
                st = ST_MISMATCH;
            r = '0;
            r.kind = KIND_STAT;
            r.status = st;
            step_results.push_back(r);
            phase = P_HDR0;
        end

        if (step_results.size() > 0) begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
        end
        foreach (step_results[i]) due_results.push_back(step_results[i]);
    endtask

    function automatic string field_diff(string nm, logic [63:0] e, logic [63:0] a);
        if (e !== a) return $sformatf(" %s exp %0h got %0h", nm, e, a);
        return "";
    endfunction

    // Compare one accepted result with the oldest prediction
    task automatic check_result();
        res_t  exp_r;
        res_t  act;
        string diffs;
        results_seen++;
        act.kind = kind_t'(m_tuser);
        act.hdr.fin = m_tdata[0];
        act.hdr.reserved_bits = m_tdata[3:1];
        act.hdr.opcode = m_tdata[7:4];
        act.hdr.masked = m_tdata[8];
        act.hdr.length_code = m_tdata[15:9];
        act.hdr.payload_length = m_tdata[79:16];
        act.hdr.mask_key = m_tdata[111:80];
        act.data_byte = m_tdata[119:112];
        act.status = status_t'(m_tdata[121:120]);
        act.last = m_tlast;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result: kind %0d tdata %h last %b",
                         $realtime, m_tuser, m_tdata, m_tlast);
        end else begin
            exp_r = due_results.pop_front();
            diffs = {field_diff("kind", exp_r.kind, act.kind),
                     field_diff("fin", exp_r.hdr.fin, act.hdr.fin),
                     field_diff("rsv", exp_r.hdr.reserved_bits, act.hdr.reserved_bits),
                     field_diff("opcode", exp_r.hdr.opcode, act.hdr.opcode),
                     field_diff("masked", exp_r.hdr.masked, act.hdr.masked),
                     field_diff("len_code", exp_r.hdr.length_code, act.hdr.length_code),
                     field_diff("pay_len", exp_r.hdr.payload_length,
                                act.hdr.payload_length),
                     field_diff("key", exp_r.hdr.mask_key, act.hdr.mask_key),
                     field_diff("data", exp_r.data_byte, act.data_byte),
                     field_diff("status", exp_r.status, act.status),
                     field_diff("last", exp_r.last, act.last),
                     field_diff("fill", 64'd0, {58'd0, m_tdata[127:122]})};
            if (diffs != "") begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result %0d mismatch:%s", $realtime, results_seen, diffs);
            end
        end
    endtask

    // Sample all channels on the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
            due_results.delete();
            mismatches = 0;
            results_seen = 0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (cfg_we) demask = cfg_wdata;
            if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
        end
        pending = due_results.size();
    end

endmodule

>>> dv/websocket_frame_parser_tb.sv
`timescale 1ns / 100ps

module websocket_frame_parser_tb;
    import wsfp_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic         cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    int mismatches;
    int pending;
    int results_seen;
    int items_sent;
    int frames_sent;
    bit quiet;
    bit want_hold;

    websocket_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    websocket_frame_parser_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (want_hold) begin
                want_hold = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 17);
            end
        end
    end

    // Offer one frame byte, with an occasional one-cycle gap, and wait for the handshake
    task automatic put_byte(input logic [7:0] b, input logic l);
        @(negedge aclk);
        if (!quiet && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Drop valid and wait for every predicted result to drain
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_demask(input logic v);
        drain();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Build a frame and send it; a nonzero cut keeps only the first bytes
    task automatic send_frame(input logic [7:0] b0, input logic msk, input logic [6:0] code,
                              input logic [63:0] ext_len, input int pay_cnt, input int cut);
        logic [7:0] bytes[$];
        int         ext_n;
        bytes.push_back(b0);
        bytes.push_back({msk, code});
        ext_n = (code == LEN_CODE_EXT16) ? 2 : (code == LEN_CODE_EXT64) ? 8 : 0;
        for (int i = ext_n - 1; i >= 0; i--) bytes.push_back(ext_len[8 * i +: 8]);
        if (msk) repeat (4) bytes.push_back(8'($urandom_range(255)));
        repeat (pay_cnt) bytes.push_back(8'($urandom_range(255)));
        if (cut > 0 && cut < bytes.size()) bytes = bytes[0:cut - 1];
        foreach (bytes[i]) put_byte(bytes[i], i == bytes.size() - 1);
        frames_sent++;
    endtask

    // Mostly well-formed frames; some short, overlong or cut inside the header
    task automatic random_frame();
        int          pick;
        int          flaw;
        int          hdr_len;
        int          pay;
        logic        msk;
        logic [6:0]  code;
        logic [63:0] len;
        pick = $urandom_range(99);
        msk = 1'($urandom_range(1));
        if (pick < 57) begin
            code = 7'($urandom_range(12));
            len = code;
        end else if (pick < 60) begin
            code = 7'($urandom_range(13, 125));
            len = code;
        end else if (pick < 78) begin
            code = LEN_CODE_EXT16;
            len = ($urandom_range(3) == 0) ? 64'($urandom_range(65535))
                                           : 64'($urandom_range(16));
        end else begin
            code = LEN_CODE_EXT64;
            len = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(16));
        end
        pay = (len > 40) ? $urandom_range(6) : int'(len);
        hdr_len = 2 + ((code == LEN_CODE_EXT16) ? 2 : (code == LEN_CODE_EXT64) ? 8 : 0)
                  + (msk ? 4 : 0);
        flaw = $urandom_range(99);
        if (flaw < 8 && pay > 0)
            pay = $urandom_range(pay - 1);
        else if (flaw < 16)
            pay += $urandom_range(1, 3);
        send_frame(8'($urandom_range(255)), msk, code, len, pay,
                   (flaw >= 94) ? $urandom_range(1, hdr_len) : 0);
    endtask

    task automatic run_phase(input int n_items, input bit hold, input bit pause);
        int stop;
        int nf;
        stop = items_sent + n_items;
        nf = 0;
        while (items_sent < stop) begin
            random_frame();
            nf++;
            if (hold && nf == 5) want_hold = 1'b1;
            if (pause && nf == 12) drain();
        end
    endtask

    // Stimulus
    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        quiet = 1'b0;
        want_hold = 1'b0;
        items_sent = 0;
        frames_sent = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed frames, demask at its reset value
        send_frame(8'hFF, 1'b0, 7'd0, 64'd0, 0, 1);
        send_frame(8'h00, 1'b1, LEN_CODE_EXT16, 64'd0, 0, 2);
        send_frame(8'h81, 1'b0, 7'd0, 64'd0, 0, 0);
        send_frame(8'h82, 1'b0, LEN_CODE_EXT64, '1, 0, 0);
        send_frame(8'h7A, 1'b1, 7'd3, 64'd3, 3, 0);
        send_frame(8'h01, 1'b0, 7'd1, 64'd1, 2, 0);

        // Random phases across demask settings, stalls and quiet stretches
        write_demask(1'b0);
        run_phase(258, 1'b1, 1'b0);
        write_demask(1'b1);
        quiet = 1'b1;
        run_phase(258, 1'b0, 1'b1);
        quiet = 1'b0;
        write_demask(1'b0);
        run_phase(258, 1'b0, 1'b0);
        write_demask(1'b1);
        run_phase(258, 1'b1, 1'b0);

        drain();
        repeat (10) @(posedge aclk);
        $display("Sent %0d frame bytes in %0d frames, checked %0d results", items_sent,
                 frames_sent, results_seen);
        $display("Covered both demask settings, malformed frames, hold-off and drain pauses");
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
